// ----- hw/rtl/rgpg_pkg.sv -----
// ----------------------------------------------------------------------------
// rgpg_pkg
// Shared types, register codes and defaults of the gradient pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none
package rgpg_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int FRAC_DEF    = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COLOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

  localparam logic [1:0] DIR_HORIZ = 2'd0;
  localparam logic [1:0] DIR_VERT  = 2'd1;
  localparam logic [1:0] DIR_DIAG  = 2'd2;

  localparam logic [31:0] FIRST_COLOR_RST  = 32'hFF0000FF;
  localparam logic [31:0] SECOND_COLOR_RST = 32'hFFFF0000;
  localparam logic [12:0] WIDTH_RST        = 13'd640;
  localparam logic [12:0] HEIGHT_RST       = 13'd480;

  // Per-word flags that travel down the chain beside the data.
  typedef struct packed {
    logic diag;   // weight comes from the square root
    logic sat;    // position at or beyond the far edge: full weight
    logic zero;   // divisor is zero: weight is zero
  } item_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rgpg_div_cell.sv -----
// ----------------------------------------------------------------------------
// rgpg_div_cell
// One step of restoring division: yields one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module rgpg_div_cell
  import rgpg_pkg::*;
#(
  parameter int DW = 25,
  parameter int QW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_vld,
  input  wire item_ctl_t     in_ctl,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [QW-1:0] in_quo,
  output logic               out_vld,
  output item_ctl_t          out_ctl,
  output logic [DW-1:0]      out_rem,
  output logic [DW-1:0]      out_den,
  output logic [QW-1:0]      out_quo
);

  logic [DW:0] rem_sh;
  logic [DW:0] diff;
  logic        ge;

  assign rem_sh = {in_rem, 1'b0};
  assign diff   = rem_sh - {1'b0, in_den};
  assign ge     = rem_sh >= {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctl <= in_ctl;
      out_den <= in_den;
      out_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      out_quo <= {in_quo[QW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rgpg_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rgpg_sqrt_cell
// One digit of a restoring square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
`default_nettype none
module rgpg_sqrt_cell
  import rgpg_pkg::*;
#(
  parameter int F = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           in_vld,
  input  wire item_ctl_t      in_ctl,
  input  wire logic [F-1:0]   in_lin,
  input  wire logic [2*F-1:0] in_rad,
  input  wire logic [F+1:0]   in_rem,
  input  wire logic [F-1:0]   in_res,
  output logic                out_vld,
  output item_ctl_t           out_ctl,
  output logic [F-1:0]        out_lin,
  output logic [2*F-1:0]      out_rad,
  output logic [F+1:0]        out_rem,
  output logic [F-1:0]        out_res
);

  logic [F+3:0] rem_sh;
  logic [F+3:0] trial;
  logic [F+3:0] diff;
  logic         ge;

  assign rem_sh = {in_rem, in_rad[2*F-1:2*F-2]};
  assign trial  = {2'b00, in_res, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctl <= in_ctl;
      out_lin <= in_lin;
      out_rad <= {in_rad[2*F-3:0], 2'b00};
      out_rem <= ge ? diff[F+1:0] : rem_sh[F+1:0];
      out_res <= {in_res[F-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rgpg_blend.sv -----
// ----------------------------------------------------------------------------
// rgpg_blend
// Mixes the two colours by the weight, all four channels, into the output word.
// ----------------------------------------------------------------------------
`default_nettype none
module rgpg_blend
  import rgpg_pkg::*;
#(
  parameter int F = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         adv,
  input  wire logic         in_vld,
  input  wire logic [F:0]   weight,
  input  wire logic [31:0]  color_a,
  input  wire logic [31:0]  color_b,
  output logic              out_vld,
  output logic [31:0]       out_pix
);

  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic [F:0]   inv;
  logic [31:0]  pix;

  assign inv = ONE - weight;

  always_comb begin
    logic [F+9:0] acc;
    pix = '0;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      acc = (F+10)'(color_a[8*k +: 8]) * (F+10)'(inv)
          + (F+10)'(color_b[8*k +: 8]) * (F+10)'(weight);
      pix[8*k +: 8] = acc[F +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix <= pix;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rgba_gradient_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// rgba_gradient_pixel_generator
// Gradient colour of one pixel, blended from two colours by position.
// ----------------------------------------------------------------------------
// One pixel word is taken every clock while the output is free or being
// taken. Each word passes through a chain of cells: two stages of squaring
// and compare, 2*FRACTION_BITS division cells giving one quotient bit each,
// FRACTION_BITS square-root cells giving one root bit each, and the blend
// stage that also holds the output word. The whole chain stalls together
// when the output is not taken. Registers must be written only while no
// word is in flight.
`default_nettype none
module rgba_gradient_pixel_generator
  import rgpg_pkg::*;
#(
  parameter int MAX_DIM       = MAX_DIM_DEF,
  parameter int FRACTION_BITS = FRAC_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [11:0]          column,
  input  wire logic [11:0]          row,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                channel_zero,
  output logic [7:0]                channel_one,
  output logic [7:0]                channel_two,
  output logic [7:0]                channel_three
);

  localparam int F    = FRACTION_BITS;
  localparam int QW   = 2 * F;
  localparam int DIMW = $clog2(MAX_DIM + 1);
  localparam int DW   = (2 * DIMW + 1 > 25) ? 2 * DIMW + 1 : 25;

  logic [31:0] first_color;
  logic [31:0] second_color;
  logic [1:0]  direction;
  logic [12:0] frame_width;
  logic [12:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_color  <= FIRST_COLOR_RST;
      second_color <= SECOND_COLOR_RST;
      direction    <= DIR_HORIZ;
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_COLOR:  first_color  <= cfg_data;
        CFG_SECOND_COLOR: second_color <= cfg_data;
        CFG_DIRECTION:    direction    <= cfg_data[1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[12:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage A: saturated dimensions and squares.
  logic [DIMW-1:0]   w_sat;
  logic [DIMW-1:0]   h_sat;
  logic              a_vld;
  logic [11:0]       a_x;
  logic [11:0]       a_y;
  logic [DIMW-1:0]   a_w;
  logic [DIMW-1:0]   a_h;
  logic [23:0]       a_sx;
  logic [23:0]       a_sy;
  logic [2*DIMW-1:0] a_sw;
  logic [2*DIMW-1:0] a_sh;

  assign w_sat = ({19'd0, frame_width} > 32'(MAX_DIM)) ? DIMW'(MAX_DIM) : DIMW'(frame_width);
  assign h_sat = ({19'd0, frame_height} > 32'(MAX_DIM)) ? DIMW'(MAX_DIM) : DIMW'(frame_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x  <= column;
      a_y  <= row;
      a_w  <= w_sat;
      a_h  <= h_sat;
      a_sx <= column * column;
      a_sy <= row * row;
      a_sw <= w_sat * w_sat;
      a_sh <= h_sat * h_sat;
    end
  end

  // Stage B: numerator, divisor and the edge cases.
  logic              diag;
  logic [DW-1:0]     num;
  logic [DW-1:0]     den;
  logic              b_vld;
  item_ctl_t         b_ctl;
  logic [DW-1:0]     b_num;
  logic [DW-1:0]     b_den;

  assign diag = direction == DIR_DIAG;

  always_comb begin
    if (diag) begin
      num = DW'(a_sx) + DW'(a_sy);
      den = DW'(a_sw) + DW'(a_sh);
    end else if (direction == DIR_VERT) begin
      num = DW'(a_y);
      den = DW'(a_h);
    end else begin
      num = DW'(a_x);
      den = DW'(a_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctl.diag <= diag;
      b_ctl.zero <= den == '0;
      b_ctl.sat  <= num >= den;
      b_num      <= num;
      b_den      <= den;
    end
  end

  // Division chain: quotient of num * 2^(2F) / den, numerator below divisor.
  logic          dv_vld [0:QW];
  item_ctl_t     dv_ctl [0:QW];
  logic [DW-1:0] dv_rem [0:QW];
  logic [DW-1:0] dv_den [0:QW];
  logic [QW-1:0] dv_quo [0:QW];

  assign dv_vld[0] = b_vld;
  assign dv_ctl[0] = b_ctl;
  assign dv_rem[0] = b_num;
  assign dv_den[0] = b_den;
  assign dv_quo[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    rgpg_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .in_vld  (dv_vld[i]),
      .in_ctl  (dv_ctl[i]),
      .in_rem  (dv_rem[i]),
      .in_den  (dv_den[i]),
      .in_quo  (dv_quo[i]),
      .out_vld (dv_vld[i+1]),
      .out_ctl (dv_ctl[i+1]),
      .out_rem (dv_rem[i+1]),
      .out_den (dv_den[i+1]),
      .out_quo (dv_quo[i+1])
    );
  end

  // Square-root chain; the linear weight is the top half of the quotient.
  logic           sq_vld [0:F];
  item_ctl_t      sq_ctl [0:F];
  logic [F-1:0]   sq_lin [0:F];
  logic [QW-1:0]  sq_rad [0:F];
  logic [F+1:0]   sq_rem [0:F];
  logic [F-1:0]   sq_res [0:F];

  assign sq_vld[0] = dv_vld[QW];
  assign sq_ctl[0] = dv_ctl[QW];
  assign sq_lin[0] = dv_quo[QW][QW-1:F];
  assign sq_rad[0] = dv_quo[QW];
  assign sq_rem[0] = '0;
  assign sq_res[0] = '0;

  for (genvar j = 0; j < F; j++) begin : g_sqrt
    rgpg_sqrt_cell #(.F(F)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .in_vld  (sq_vld[j]),
      .in_ctl  (sq_ctl[j]),
      .in_lin  (sq_lin[j]),
      .in_rad  (sq_rad[j]),
      .in_rem  (sq_rem[j]),
      .in_res  (sq_res[j]),
      .out_vld (sq_vld[j+1]),
      .out_ctl (sq_ctl[j+1]),
      .out_lin (sq_lin[j+1]),
      .out_rad (sq_rad[j+1]),
      .out_rem (sq_rem[j+1]),
      .out_res (sq_res[j+1])
    );
  end

  logic [F:0]  weight;
  logic [31:0] pix;

  always_comb begin
    if (sq_ctl[F].zero) begin
      weight = '0;
    end else if (sq_ctl[F].sat) begin
      weight = (F+1)'(1) << F;
    end else if (sq_ctl[F].diag) begin
      weight = {1'b0, sq_res[F]};
    end else begin
      weight = {1'b0, sq_lin[F]};
    end
  end

  rgpg_blend #(.F(F)) u_blend (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (sq_vld[F]),
    .weight  (weight),
    .color_a (first_color),
    .color_b (second_color),
    .out_vld (out_valid),
    .out_pix (pix)
  );

  assign channel_zero  = pix[7:0];
  assign channel_one   = pix[15:8];
  assign channel_two   = pix[23:16];
  assign channel_three = pix[31:24];

endmodule
`default_nettype wire

// ----- hw/rtl/rgpg_checker.sv -----
// ----------------------------------------------------------------------------
// rgpg_checker
// Port-level checks on the gradient pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none
module rgpg_checker
  import rgpg_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] channel_zero,
  input wire logic [7:0] channel_three
);

  // A word held at the output stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(channel_zero) && $stable(channel_three))
    else $error("output word changed while stalled");

  // The chain only stalls when the output is held back.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input refused with the output free");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

endmodule

bind rgba_gradient_pixel_generator rgpg_checker u_rgpg_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .channel_zero  (channel_zero),
  .channel_three (channel_three)
);
`default_nettype wire
